// ----- sv/ocm_pkg.sv -----
// ocm_pkg: word types, operation and status codes shared by the offset / line-column map
// entry layout and position ordering used by both stores
// no dependencies
package ocm_pkg;

   localparam int unsigned ENTRY_CNT_W = 9;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_FWD   = 2'd2;
   localparam logic [1:0] KIND_REV   = 2'd3;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_EXACT   = 2'd1;
   localparam logic [1:0] STATUS_NOMATCH = 2'd2;
   localparam logic [1:0] STATUS_LIMIT   = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] offset;
      logic [15:0] line;
      logic [15:0] column;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [15:0]            found_line;
      logic [15:0]            found_column;
      logic [31:0]            found_offset;
      logic [ENTRY_CNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] offset;
      logic [15:0] line;
      logic [15:0] column;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   // order by (line, column, offset): true when a sorts after b
   function automatic logic pos_above(entry_type a, entry_type b);
      logic res;
      if (a.line != b.line) begin
         res = a.line > b.line;
      end else if (a.column != b.column) begin
         res = a.column > b.column;
      end else begin
         res = a.offset > b.offset;
      end
      return res;
   endfunction

endpackage

// ----- sv/offset_line_column_map.sv -----
// offset_line_column_map: clear, load into an empty or full table and query on an empty table
// go straight to the response; a load otherwise moves entries up by the sorted insert, one per
// cycle; a query runs binary-search reads, then an extra read of the following entry for an
// inexact reverse query; one word in flight: the next is taken once a result has moved into
// the output register; reset is synchronous: clears count and control only
module offset_line_column_map #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ocm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ocm_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

   logic                        done_valid, done_ready;
   ocm_pkg::rsp_type            done_data;
   logic [IDX_W-1:0]            rd_addr;
   logic                        off_wr_en, pos_wr_en;
   logic [IDX_W-1:0]            off_wr_addr, pos_wr_addr;
   logic [ocm_pkg::ENTRY_W-1:0] off_wr_data, pos_wr_data, off_rd_data, pos_rd_data;

   logic                        rsp_valid_ff, rsp_valid_in;
   ocm_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   ocm_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_data   (done_data),
      .rd_addr     (rd_addr),
      .off_wr_en   (off_wr_en),
      .off_wr_addr (off_wr_addr),
      .off_wr_data (off_wr_data),
      .off_rd_data (off_rd_data),
      .pos_wr_en   (pos_wr_en),
      .pos_wr_addr (pos_wr_addr),
      .pos_wr_data (pos_wr_data),
      .pos_rd_data (pos_rd_data)
   );

   // entries in load order
   ocm_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ocm_pkg::ENTRY_W)) u_off_ram (
      .clock   (clock),
      .wr_en   (off_wr_en),
      .wr_addr (off_wr_addr),
      .wr_data (off_wr_data),
      .rd_addr (rd_addr),
      .rd_data (off_rd_data)
   );

   // entries sorted by line, column, offset
   ocm_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ocm_pkg::ENTRY_W)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (pos_wr_addr),
      .wr_data (pos_wr_data),
      .rd_addr (rd_addr),
      .rd_data (pos_rd_data)
   );

   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/ocm_ram.sv -----
// ocm_ram: single-port-write, single-port-read synchronous memory with registered read data;
// contents undefined until written
// no dependencies
module ocm_ram #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 64,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ocm_seq.sv -----
// ocm_seq: sequencer for loads (sorted insert by shifting), clears and binary-search queries
// drives the read/write ports of both stores; depends on ocm_pkg
module ocm_seq #(
   parameter int unsigned TABLE_DEPTH = 256,
   localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1),
   localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ocm_pkg::req_type              req_data,
   output logic                          done_valid,
   input  logic                          done_ready,
   output ocm_pkg::rsp_type              done_data,
   output logic [IDX_W-1:0]              rd_addr,
   output logic                          off_wr_en,
   output logic [IDX_W-1:0]              off_wr_addr,
   output logic [ocm_pkg::ENTRY_W-1:0]   off_wr_data,
   input  logic [ocm_pkg::ENTRY_W-1:0]   off_rd_data,
   output logic                          pos_wr_en,
   output logic [IDX_W-1:0]              pos_wr_addr,
   output logic [ocm_pkg::ENTRY_W-1:0]   pos_wr_data,
   input  logic [ocm_pkg::ENTRY_W-1:0]   pos_rd_data
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_INS      = 7'b0000010,
      ST_INS_LAST = 7'b0000100,
      ST_SEARCH   = 7'b0001000,
      ST_CHECK    = 7'b0010000,
      ST_NEXT     = 7'b0100000,
      ST_RESP     = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [CNT_W-1:0]   right_ff, right_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   ocm_pkg::req_type   req_ff, req_in;
   ocm_pkg::rsp_type   res_ff, res_in;

   ocm_pkg::entry_type off_rd_e, pos_rd_e, new_entry, held_entry;
   logic               le_fwd, le_rev, le_sel;
   logic [CNT_W-1:0]   left_n, right_n, span_n, mid_n, next_idx;
   logic               accept;

   function automatic logic [ocm_pkg::ENTRY_CNT_W-1:0] to_entry_cnt(logic [CNT_W-1:0] c);
      logic [CNT_W+ocm_pkg::ENTRY_CNT_W-1:0] w;
      w = {{ocm_pkg::ENTRY_CNT_W{1'b0}}, c};
      return w[ocm_pkg::ENTRY_CNT_W-1:0];
   endfunction

   assign off_rd_e   = off_rd_data;
   assign pos_rd_e   = pos_rd_data;
   assign new_entry  = '{offset: req_data.offset, line: req_data.line,
                         column: req_data.column};
   assign held_entry = '{offset: req_ff.offset, line: req_ff.line,
                         column: req_ff.column};

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign done_valid = (state_ff == ST_RESP);
   assign done_data  = res_ff;

   // one search step: the word read last cycle is the entry at mid_ff
   assign le_fwd = off_rd_e.offset <= req_ff.offset;
   assign le_rev = (pos_rd_e.line < req_ff.line) ||
                   ((pos_rd_e.line == req_ff.line) && (pos_rd_e.column <= req_ff.column));
   assign le_sel   = (req_ff.kind == ocm_pkg::KIND_REV) ? le_rev : le_fwd;
   assign left_n   = le_sel ? mid_ff : left_ff;
   assign right_n  = le_sel ? right_ff : mid_ff;
   assign span_n   = right_n - left_n;
   assign mid_n    = left_n + (span_n >> 1);
   assign next_idx = left_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      mid_in      = mid_ff;
      idx_in      = idx_ff;
      req_in      = req_ff;
      res_in      = res_ff;
      rd_addr     = '0;
      off_wr_en   = 1'b0;
      off_wr_addr = count_ff[IDX_W-1:0];
      off_wr_data = new_entry;
      pos_wr_en   = 1'b0;
      pos_wr_addr = '0;
      pos_wr_data = new_entry;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in             = req_data;
               res_in             = '0;
               res_in.entry_count = to_entry_cnt(count_ff);
               state_in           = ST_RESP;
               case (req_data.kind)
                  ocm_pkg::KIND_LOAD: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        res_in.status = ocm_pkg::STATUS_LIMIT;
                     end else begin
                        off_wr_en          = 1'b1;
                        count_in           = count_ff + CNT_W'(1);
                        res_in.status      = ocm_pkg::STATUS_DONE;
                        res_in.entry_count = to_entry_cnt(count_ff + CNT_W'(1));
                        if (count_ff == '0) begin
                           pos_wr_en = 1'b1;
                        end else begin
                           // walk down from the top entry, shifting up as we go
                           idx_in   = IDX_W'(count_ff - CNT_W'(1));
                           rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                           state_in = ST_INS;
                        end
                     end
                  end
                  ocm_pkg::KIND_CLEAR: begin
                     count_in           = '0;
                     res_in.status      = ocm_pkg::STATUS_DONE;
                     res_in.entry_count = '0;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        res_in.status = ocm_pkg::STATUS_LIMIT;
                     end else begin
                        left_in  = '0;
                        right_in = count_ff;
                        if (count_ff > CNT_W'(1)) begin
                           mid_in   = count_ff >> 1;
                           rd_addr  = IDX_W'(count_ff >> 1);
                           state_in = ST_SEARCH;
                        end else begin
                           rd_addr  = '0;
                           state_in = ST_CHECK;
                        end
                     end
                  end
               endcase
            end
         end
         ST_INS: begin
            pos_wr_en   = 1'b1;
            pos_wr_addr = IDX_W'(idx_ff + IDX_W'(1));
            if (ocm_pkg::pos_above(pos_rd_e, held_entry)) begin
               pos_wr_data = pos_rd_e;
               if (idx_ff == '0) begin
                  state_in = ST_INS_LAST;
               end else begin
                  idx_in  = idx_ff - IDX_W'(1);
                  rd_addr = idx_ff - IDX_W'(1);
               end
            end else begin
               pos_wr_data = held_entry;
               state_in    = ST_RESP;
            end
         end
         ST_INS_LAST: begin
            pos_wr_en   = 1'b1;
            pos_wr_addr = '0;
            pos_wr_data = held_entry;
            state_in    = ST_RESP;
         end
         ST_SEARCH: begin
            left_in  = left_n;
            right_in = right_n;
            if (span_n > CNT_W'(1)) begin
               mid_in  = mid_n;
               rd_addr = mid_n[IDX_W-1:0];
            end else begin
               rd_addr  = left_n[IDX_W-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_RESP;
            if (req_ff.kind == ocm_pkg::KIND_FWD) begin
               if (off_rd_e.offset == req_ff.offset) begin
                  res_in.status       = ocm_pkg::STATUS_EXACT;
                  res_in.found_line   = off_rd_e.line;
                  res_in.found_column = off_rd_e.column;
               end else begin
                  res_in.status = ocm_pkg::STATUS_NOMATCH;
               end
            end else begin
               if ((pos_rd_e.line == req_ff.line) && (pos_rd_e.column == req_ff.column)) begin
                  res_in.status       = ocm_pkg::STATUS_EXACT;
                  res_in.found_offset = pos_rd_e.offset;
               end else begin
                  res_in.status = ocm_pkg::STATUS_NOMATCH;
                  // look at the following entry for one on the same line
                  if (next_idx < count_ff) begin
                     rd_addr  = next_idx[IDX_W-1:0];
                     state_in = ST_NEXT;
                  end
               end
            end
         end
         ST_NEXT: begin
            if (pos_rd_e.line == req_ff.line) begin
               res_in.found_offset = pos_rd_e.offset;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      mid_ff   <= mid_in;
      idx_ff   <= idx_in;
      req_ff   <= req_in;
      res_ff   <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_ins_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS) |-> ((CNT_W'(idx_ff) + CNT_W'(1)) < count_ff))
      else $error("insert shift beyond filled part of table");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((mid_ff > left_ff) && (mid_ff < right_ff) &&
                                  (right_ff <= count_ff)))
      else $error("search window out of range");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (done_valid && !done_ready) |=> (done_valid && $stable(done_data)))
      else $error("finished word lost while output stage busy");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.kind == ocm_pkg::KIND_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty table");

endmodule
